@@ design/vsfl_pkg.sv @@
// Package for the vertex slot free list: field widths, operation and status
// codes, state encoding and the control structs between top level and allocator.
// No dependencies.
package vsfl_pkg;

  localparam int IDX_W          = 10;
  localparam int COORD_W        = 32;
  localparam int SLOT_COUNT_DEF = 1024;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOT_LIVE = 2'd2
  } status_e;

  typedef enum logic [0:0] {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  // Commands to the allocator, applied at the write-back edge
  typedef struct packed {
    logic take_free;   // pop the free-list head
    logic take_fresh;  // hand out the next never-used slot
    logic push;        // push a released slot onto the free list
  } alloc_cmd_t;

  typedef struct packed {
    logic list_empty;
    logic fresh_left;
  } alloc_sts_t;

endpackage

@@ design/vsfl_if.sv @@
// Request and response channel interfaces for the vertex slot free list.
// Depends on vsfl_pkg.
interface vsfl_req_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        op;
  logic [vsfl_pkg::IDX_W-1:0]        slot_index;
  logic [vsfl_pkg::COORD_W-1:0]      in_x;
  logic [vsfl_pkg::COORD_W-1:0]      in_y;
  logic [vsfl_pkg::COORD_W-1:0]      in_z;

  modport source (output valid, op, slot_index, in_x, in_y, in_z, input ready);
  modport sink   (input valid, op, slot_index, in_x, in_y, in_z, output ready);
endinterface

interface vsfl_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [vsfl_pkg::IDX_W-1:0]        out_slot;
  logic [vsfl_pkg::COORD_W-1:0]      out_x;
  logic [vsfl_pkg::COORD_W-1:0]      out_y;
  logic [vsfl_pkg::COORD_W-1:0]      out_z;
  logic                              is_live;
  logic [1:0]                        status;

  modport source (output valid, out_slot, out_x, out_y, out_z, is_live, status,
                  input ready);
  modport sink   (input valid, out_slot, out_x, out_y, out_z, is_live, status,
                  output ready);
endinterface

@@ design/vsfl_ram.sv @@
// Simple dual-port synchronous RAM, one write and one registered read port.
// No package dependencies.
module vsfl_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // hold read data until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/vsfl_alloc.sv @@
// Slot allocator: free-list head and count of never-used slots handed out.
// Depends on vsfl_pkg.
module vsfl_alloc #(
  parameter int SLOT_COUNT = vsfl_pkg::SLOT_COUNT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  vsfl_pkg::alloc_cmd_t            cmd_i,
  input  logic [$clog2(SLOT_COUNT+1)-1:0] link_i,
  input  logic [$clog2(SLOT_COUNT)-1:0]   push_slot_i,
  output logic [$clog2(SLOT_COUNT+1)-1:0] head_o,
  output logic [$clog2(SLOT_COUNT+1)-1:0] fresh_o,
  output vsfl_pkg::alloc_sts_t            sts_o
);

  localparam int CntW = $clog2(SLOT_COUNT + 1);
  localparam logic [CntW-1:0] EmptyMark = CntW'(SLOT_COUNT);

  logic [CntW-1:0] head_q, head_d;
  logic [CntW-1:0] fresh_q, fresh_d;

  always_comb begin
    head_d  = head_q;
    fresh_d = fresh_q;
    if (cmd_i.take_free) begin
      head_d = link_i;
    end else if (cmd_i.push) begin
      head_d = CntW'(push_slot_i);
    end
    if (cmd_i.take_fresh) begin
      fresh_d = fresh_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= EmptyMark;
      fresh_q <= '0;
    end else begin
      head_q  <= head_d;
      fresh_q <= fresh_d;
    end
  end

  assign head_o           = head_q;
  assign fresh_o          = fresh_q;
  assign sts_o.list_empty = (head_q == EmptyMark);
  assign sts_o.fresh_left = (fresh_q != EmptyMark);

endmodule

@@ design/vertex_slot_free_list_top.sv @@
// Vertex slot store with LIFO free-list allocation. Depends on vsfl_pkg,
// vsfl_if, vsfl_ram and vsfl_alloc.
//
// Each request word (add, remove or read) gives exactly one response word and
// passes through the idle state, which reads the per-slot metadata RAM
// ({live, link}) and the coordinate RAM, and then the exec state, which
// modifies, writes back and loads the response register. The metadata RAM's
// registered read sets this order: its link field must be known before the
// free-list head can advance. A request is taken whenever the block is idle,
// even while the previous response still waits; write-back stalls only if
// that response is not yet taken. Nothing is cleared after reset and no
// clearing pass runs: a slot's live bit counts only below the number of
// never-used slots handed out, so the block is ready straight after reset.
// Slots above 1023 (for SLOT_COUNT above 1024) are handed out by add but
// cannot be named by slot_index.
module vertex_slot_free_list_top #(
  parameter int SLOT_COUNT = vsfl_pkg::SLOT_COUNT_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  vsfl_req_if.sink     req_i,
  vsfl_rsp_if.source   rsp_o
);

  localparam int AddrW = $clog2(SLOT_COUNT);
  localparam int CntW  = $clog2(SLOT_COUNT + 1);
  localparam int WideW = (CntW > vsfl_pkg::IDX_W) ? CntW : vsfl_pkg::IDX_W;
  localparam int MetaW = CntW + 1;
  localparam int CrdW  = 3 * vsfl_pkg::COORD_W;

  // ---------------------------------------------------------------- control
  vsfl_pkg::state_e state_q, state_d;

  logic                         accept;
  logic                         commit;
  logic                         out_free;

  // request word held for the write-back cycle
  logic [1:0]                   op_q;
  logic [WideW-1:0]             idx_q;
  logic [CrdW-1:0]              crd_q;

  // allocator
  vsfl_pkg::alloc_cmd_t         cmd;
  vsfl_pkg::alloc_sts_t         sts;
  logic [CntW-1:0]              head;
  logic [CntW-1:0]              fresh;

  // memories
  logic [AddrW-1:0]             meta_raddr;
  logic [MetaW-1:0]             meta_rdata;
  logic [MetaW-1:0]             meta_wdata;
  logic                         meta_we;
  logic [CrdW-1:0]              crd_rdata;
  logic                         crd_we;
  logic [WideW-1:0]             slot_sel;

  // response computed in the write-back cycle
  logic [WideW-1:0]             res_slot;
  logic [CrdW-1:0]              res_crd;
  logic                         res_live;
  vsfl_pkg::status_e            res_status;
  logic                         live_rd;
  logic                         in_range;

  // response register
  logic                         out_valid_q;
  logic [vsfl_pkg::IDX_W-1:0]   out_slot_q;
  logic [CrdW-1:0]              out_crd_q;
  logic                         out_live_q;
  logic [1:0]                   out_status_q;

  assign accept   = req_i.valid && req_i.ready;
  assign out_free = !out_valid_q || rsp_o.ready;
  assign commit   = (state_q == vsfl_pkg::S_EXEC) && out_free;

  always_comb begin
    state_d     = state_q;
    req_i.ready = 1'b0;
    case (state_q)
      vsfl_pkg::S_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          state_d = vsfl_pkg::S_EXEC;
        end
      end
      vsfl_pkg::S_EXEC: begin
        if (out_free) begin
          state_d = vsfl_pkg::S_IDLE;
        end
      end
      default: state_d = vsfl_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vsfl_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // hold the request word for write-back
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= req_i.op;
      idx_q <= WideW'(req_i.slot_index);
      crd_q <= {req_i.in_z, req_i.in_y, req_i.in_x};
    end
  end

  // ---------------------------------------------------------------- read
  // Add reads the head's link; remove and read read the addressed slot.
  always_comb begin
    if (req_i.op == vsfl_pkg::OP_ADD) begin
      meta_raddr = head[AddrW-1:0];
    end else begin
      meta_raddr = AddrW'(req_i.slot_index);
    end
  end

  vsfl_ram #(
    .DATA_W (MetaW),
    .DEPTH  (SLOT_COUNT)
  ) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (slot_sel[AddrW-1:0]),
    .wdata_i (meta_wdata),
    .re_i    (accept),
    .raddr_i (meta_raddr),
    .rdata_o (meta_rdata)
  );

  vsfl_ram #(
    .DATA_W (CrdW),
    .DEPTH  (SLOT_COUNT)
  ) u_crd_ram (
    .clk_i   (clk_i),
    .we_i    (crd_we),
    .waddr_i (slot_sel[AddrW-1:0]),
    .wdata_i (crd_q),
    .re_i    (accept),
    .raddr_i (AddrW'(req_i.slot_index)),
    .rdata_o (crd_rdata)
  );

  vsfl_alloc #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_alloc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .link_i      (meta_rdata[CntW-1:0]),
    .push_slot_i (idx_q[AddrW-1:0]),
    .head_o      (head),
    .fresh_o     (fresh),
    .sts_o       (sts)
  );

  // ---------------------------------------------------------------- modify
  // A slot at or above the fresh count was never handed out, so its stored
  // live bit is stale and reads as zero.
  assign in_range = idx_q < WideW'(SLOT_COUNT);
  assign live_rd  = meta_rdata[CntW] && (idx_q < WideW'(fresh));

  always_comb begin
    cmd        = '0;
    meta_we    = 1'b0;
    crd_we     = 1'b0;
    meta_wdata = '0;
    slot_sel   = idx_q;
    res_slot   = '0;
    res_crd    = '0;
    res_live   = 1'b0;
    res_status = vsfl_pkg::ST_OK;
    case (op_q)
      vsfl_pkg::OP_ADD: begin
        if (!sts.list_empty) begin
          slot_sel      = WideW'(head);
          cmd.take_free = commit;
        end else begin
          slot_sel       = WideW'(fresh);
          cmd.take_fresh = commit && sts.fresh_left;
        end
        if (!sts.list_empty || sts.fresh_left) begin
          meta_we    = commit;
          crd_we     = commit;
          meta_wdata = {1'b1, CntW'(0)};
          res_slot   = slot_sel;
          res_live   = 1'b1;
        end else begin
          res_status = vsfl_pkg::ST_FULL;
        end
      end
      vsfl_pkg::OP_REMOVE: begin
        res_slot = idx_q;
        if (live_rd) begin
          meta_we    = commit;
          meta_wdata = {1'b0, head};
          cmd.push   = commit;
        end else begin
          res_status = vsfl_pkg::ST_NOT_LIVE;
        end
      end
      vsfl_pkg::OP_READ: begin
        res_slot = idx_q;
        if (in_range) begin
          res_crd  = crd_rdata;
          res_live = live_rd;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- response
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_slot_q   <= res_slot[vsfl_pkg::IDX_W-1:0];
      out_crd_q    <= res_crd;
      out_live_q   <= res_live;
      out_status_q <= res_status;
    end
  end

  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.out_slot = out_slot_q;
  assign rsp_o.out_x    = out_crd_q[vsfl_pkg::COORD_W-1:0];
  assign rsp_o.out_y    = out_crd_q[2*vsfl_pkg::COORD_W-1:vsfl_pkg::COORD_W];
  assign rsp_o.out_z    = out_crd_q[CrdW-1:2*vsfl_pkg::COORD_W];
  assign rsp_o.is_live  = out_live_q;
  assign rsp_o.status   = out_status_q;

  // ---------------------------------------------------------------- checks
  a_alloc_one_cmd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.take_free, cmd.take_fresh, cmd.push}))
    else $error("allocator given more than one command");

  a_fresh_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fresh <= CntW'(SLOT_COUNT))
    else $error("fresh count beyond slot count");

  a_commit_gives_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> rsp_o.valid)
    else $error("write-back without a response word");

  a_accept_to_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == vsfl_pkg::S_EXEC))
    else $error("accepted word not taken to write-back");

endmodule

@@ sim/tb_vertex_slot_free_list_top.sv @@
// Self-checking testbench for vertex_slot_free_list_top: add, remove and read words
// are checked against a predictor that keeps its own slot store and free list.
// Depends on vsfl_pkg, vsfl_if and the block's RTL.
`timescale 1ns / 1ps

module tb_vertex_slot_free_list_top;

  localparam int          SLOTS        = vsfl_pkg::SLOT_COUNT_DEF;
  localparam logic [10:0] EMPTY_MARK   = 11'(SLOTS);
  localparam logic [1:0]  OP_UNDEF     = 2'd3;   // no operation behind this code
  localparam int          ITEMS_TARGET = 1450;
  localparam int          CHURN_MIN    = 200;
  localparam int          DRAIN_CYCLES = 16;
  localparam int          CYCLE_LIMIT  = 1000000;
  localparam logic [31:0] ONES         = 32'hFFFF_FFFF;

  // One request word as the predictor sees it
  typedef struct packed {
    logic [1:0]                   op;
    logic [vsfl_pkg::IDX_W-1:0]   slot;
    logic [vsfl_pkg::COORD_W-1:0] x;
    logic [vsfl_pkg::COORD_W-1:0] y;
    logic [vsfl_pkg::COORD_W-1:0] z;
  } vertex_cmd_t;

  // One response word as the block should give it
  typedef struct packed {
    logic [vsfl_pkg::IDX_W-1:0]   slot;
    logic [vsfl_pkg::COORD_W-1:0] x;
    logic [vsfl_pkg::COORD_W-1:0] y;
    logic [vsfl_pkg::COORD_W-1:0] z;
    logic                         live;
    logic [1:0]                   status;
  } vertex_answer_t;

  logic clk_i;
  logic rst_ni;

  vsfl_req_if req_if ();
  vsfl_rsp_if rsp_if ();

  vertex_slot_free_list_top #(
    .SLOT_COUNT(SLOTS)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // Predictor state: its own copy of the free list and the slot store
  logic [10:0]                    free_top;
  int                             fresh_used;
  logic [10:0]                    link_mem [SLOTS];
  logic [3*vsfl_pkg::COORD_W-1:0] coord_mem [SLOTS];
  bit                             live_mem [SLOTS];
  int                             live_slots [$];   // live slots, for picking legal removes
  int                             full_answers;

  vertex_answer_t answer_q [$];          // expected response words, oldest first
  int             fail_count;
  int             items_sent;
  int             cycle_count;
  bit             feed_calm;             // sender: no gaps while set
  bit             drain_calm;            // receiver: no stalls while set
  int             stall_left;

  // Clock: 10 ns period
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Watchdog: a hung handshake ends the run here
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Gap length for either side: mostly none or short, now and then long
  function automatic int pick_gap(bit calm);
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Coordinate word with a bias towards the extremes
  function automatic logic [31:0] pick_coord();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return ONES;
    return $urandom;
  endfunction

  function automatic vertex_cmd_t make_cmd(logic [1:0] op, int slot, logic [31:0] x,
                                           logic [31:0] y, logic [31:0] z);
    vertex_cmd_t c;
    c.op   = op;
    c.slot = slot[vsfl_pkg::IDX_W-1:0];
    c.x    = x;
    c.y    = y;
    c.z    = z;
    return c;
  endfunction

  // Work out the response to one accepted word and advance the predictor state
  task automatic predict_vertex_op(input vertex_cmd_t c, output vertex_answer_t a);
    int slot;
    int hits [$];
    a    = '0;
    slot = int'(c.slot);
    case (c.op)
      vsfl_pkg::OP_ADD: begin
        // pop the free list first, else hand out a never-used slot
        if (free_top != EMPTY_MARK) begin
          slot     = int'(free_top);
          free_top = link_mem[slot];
        end else if (fresh_used < SLOTS) begin
          slot = fresh_used;
          fresh_used++;
        end else begin
          slot = -1;
        end
        if (slot < 0) begin
          a.status = vsfl_pkg::ST_FULL;
          full_answers++;
        end else begin
          coord_mem[slot] = {c.z, c.y, c.x};
          live_mem[slot]  = 1'b1;
          live_slots      = {live_slots, slot};
          a.slot          = slot[vsfl_pkg::IDX_W-1:0];
          a.live          = 1'b1;
        end
      end
      vsfl_pkg::OP_REMOVE: begin
        a.slot = c.slot;
        if (slot < SLOTS && live_mem[slot]) begin
          link_mem[slot] = free_top;
          free_top       = 11'(slot);
          live_mem[slot] = 1'b0;
          hits = live_slots.find_first_index(item) with (item == slot);
          if (hits.size() > 0) live_slots.delete(hits[0]);
        end else begin
          a.status = vsfl_pkg::ST_NOT_LIVE;
        end
      end
      vsfl_pkg::OP_READ: begin
        a.slot = c.slot;
        if (slot < SLOTS) begin
          {a.z, a.y, a.x} = coord_mem[slot];
          a.live          = live_mem[slot];
        end
      end
      default: ;   // spare code: answer all zero, touch nothing
    endcase
  endtask

  // Compare one response field, report and count a mismatch
  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%08h, got 0x%08h", name, want, got);
      fail_count++;
    end
  endtask

  // Response side: check each accepted word, then pick ready for the next edge
  always @(posedge clk_i) begin
    vertex_answer_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (answer_q.size() == 0) begin
        $error("response word for slot %0d with nothing expected", rsp_if.out_slot);
        fail_count++;
      end else begin
        want = answer_q.pop_front();
        check_field("out_slot", 32'(want.slot), 32'(rsp_if.out_slot));
        check_field("out_x", want.x, rsp_if.out_x);
        check_field("out_y", want.y, rsp_if.out_y);
        check_field("out_z", want.z, rsp_if.out_z);
        check_field("is_live", 32'(want.live), 32'(rsp_if.is_live));
        check_field("status", 32'(want.status), 32'(rsp_if.status));
      end
    end
    // re-roll the receiver's mood now and then so that calm stretches occur
    if (cycle_count % 64 == 0) drain_calm <= ($urandom_range(0, 3) == 0);
    if (stall_left > 0) begin
      rsp_if.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else begin
      rsp_if.ready <= 1'b1;
      stall_left   <= pick_gap(drain_calm);
    end
  end

  // Send one word: hold it until accepted, predict its answer, then maybe idle
  task automatic send_word(input vertex_cmd_t c);
    vertex_answer_t a;
    int             gap;
    req_if.valid      <= 1'b1;
    req_if.op         <= c.op;
    req_if.slot_index <= c.slot;
    req_if.in_x       <= c.x;
    req_if.in_y       <= c.y;
    req_if.in_z       <= c.z;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    predict_vertex_op(c, a);
    answer_q = {answer_q, a};
    items_sent++;
    gap = pick_gap(feed_calm);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // One random word; add_pct and remove_pct set the mix, the rest are reads
  task automatic send_random_word(input int add_pct, input int remove_pct);
    int roll;
    int slot;
    roll = $urandom_range(0, 99);
    if (fresh_used == 0 || roll < add_pct) begin
      send_word(make_cmd(vsfl_pkg::OP_ADD, $urandom_range(0, SLOTS - 1), pick_coord(),
                         pick_coord(), pick_coord()));
    end else if (roll < add_pct + remove_pct) begin
      // mostly live slots; the rest hit any index, freed or never handed out
      if (live_slots.size() > 0 && $urandom_range(0, 9) < 7)
        slot = live_slots[$urandom_range(0, live_slots.size() - 1)];
      else
        slot = $urandom_range(0, SLOTS - 1);
      send_word(make_cmd(vsfl_pkg::OP_REMOVE, slot, $urandom, $urandom, $urandom));
    end else begin
      // read only slots that have been written at least once
      if (live_slots.size() > 0 && $urandom_range(0, 1) == 0)
        slot = live_slots[$urandom_range(0, live_slots.size() - 1)];
      else
        slot = $urandom_range(0, fresh_used - 1);
      send_word(make_cmd(vsfl_pkg::OP_READ, slot, $urandom, $urandom, $urandom));
    end
  endtask

  // Adds with extreme and alternating coordinate patterns, read back at once
  task automatic test_add_and_read();
    send_word(make_cmd(vsfl_pkg::OP_ADD, 0, '0, '0, '0));
    send_word(make_cmd(vsfl_pkg::OP_ADD, 0, ONES, ONES, ONES));
    send_word(make_cmd(vsfl_pkg::OP_ADD, 0, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA));
    send_word(make_cmd(vsfl_pkg::OP_ADD, 0, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555));
    for (int s = 0; s < 4; s++)
      send_word(make_cmd(vsfl_pkg::OP_READ, s, $urandom, $urandom, $urandom));
  endtask

  // Remove, remove of a dead slot, read of a freed slot and LIFO reuse
  task automatic test_remove_and_reuse();
    send_word(make_cmd(vsfl_pkg::OP_REMOVE, 1, '0, '0, '0));
    send_word(make_cmd(vsfl_pkg::OP_REMOVE, 1, '0, '0, '0));
    send_word(make_cmd(vsfl_pkg::OP_READ, 1, '0, '0, '0));
    send_word(make_cmd(vsfl_pkg::OP_REMOVE, 3, '0, '0, '0));
    send_word(make_cmd(vsfl_pkg::OP_ADD, 1023, 32'h1234_5678, 32'h0, ONES));
    send_word(make_cmd(vsfl_pkg::OP_ADD, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1));
    send_word(make_cmd(vsfl_pkg::OP_ADD, 0, $urandom, $urandom, $urandom));
    send_word(make_cmd(vsfl_pkg::OP_REMOVE, SLOTS - 1, ONES, ONES, ONES));
    send_word(make_cmd(vsfl_pkg::OP_REMOVE, 512, '0, '0, '0));
    send_word(make_cmd(vsfl_pkg::OP_REMOVE, 0, '0, '0, '0));
    send_word(make_cmd(vsfl_pkg::OP_REMOVE, 2, '0, '0, '0));
    send_word(make_cmd(vsfl_pkg::OP_READ, 0, '0, '0, '0));
    send_word(make_cmd(vsfl_pkg::OP_ADD, 0, $urandom, $urandom, $urandom));
    send_word(make_cmd(vsfl_pkg::OP_ADD, 0, $urandom, $urandom, $urandom));
  endtask

  // The spare op code must leave the store alone and answer all zero
  task automatic test_undefined_op();
    send_word(make_cmd(OP_UNDEF, SLOTS - 1, ONES, ONES, ONES));
    send_word(make_cmd(OP_UNDEF, $urandom_range(0, SLOTS - 1), $urandom, $urandom,
                       $urandom));
  endtask

  // Add-heavy traffic until the store has reported full a few times
  task automatic test_fill_to_full();
    int n;
    n = 0;
    while (full_answers < 3) begin
      if (n % 100 == 0) feed_calm = ($urandom_range(0, 3) == 0);
      send_random_word(88, 6);
      n++;
    end
  endtask

  // Mixed traffic that keeps the free list growing and shrinking
  task automatic test_random_churn();
    int count;
    count = ITEMS_TARGET - items_sent;
    if (count < CHURN_MIN) count = CHURN_MIN;
    for (int n = 0; n < count; n++) begin
      if (n % 100 == 0) feed_calm = ($urandom_range(0, 3) == 0);
      send_random_word(35, 40);
    end
  endtask

  initial begin
    // initialise predictor state to the block's reset state
    free_top     = EMPTY_MARK;
    fresh_used   = 0;
    full_answers = 0;
    fail_count   = 0;
    items_sent   = 0;
    cycle_count  = 0;
    stall_left   = 0;
    feed_calm    = 1'b0;
    drain_calm   = 1'b0;
    rsp_if.ready = 1'b0;
    for (int s = 0; s < SLOTS; s++) live_mem[s] = 1'b0;

    // drive every input to a known value from the start
    rst_ni            <= 1'b0;
    req_if.valid      <= 1'b0;
    req_if.op         <= vsfl_pkg::OP_ADD;
    req_if.slot_index <= '0;
    req_if.in_x       <= '0;
    req_if.in_y       <= '0;
    req_if.in_z       <= '0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_add_and_read();
    test_remove_and_reuse();
    test_undefined_op();
    test_fill_to_full();
    test_random_churn();

    // stop sending, let outstanding words drain, then settle
    req_if.valid <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
